>>> rtl/sm4_block_encrypt_assert.svh
// Assertion macros used by the checker of the SM4 encrypt block.
`ifndef SM4_BLOCK_ENCRYPT_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SM4_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SM4_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/sm4_pkg.sv
package sm4_pkg;

    localparam int ROUND_W  = 5;
    localparam int WORD_W   = 32;
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 128;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd31;

    // Item kind carried on tuser
    typedef enum logic {
        OP_WRITE_KEY = 1'b0,
        OP_ENCRYPT   = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic               key_wr;
        logic               load_words;
        logic               round_step;
        logic               load_out;
        logic [ROUND_W-1:0] rd_addr;
    } ctrl_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

endpackage

>>> rtl/sm4_key_ram.sv
module sm4_key_ram
    import sm4_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ROUND_W-1:0] wr_addr,
    input  logic [WORD_W-1:0]  wr_data,
    input  logic [ROUND_W-1:0] rd_addr,
    output logic [WORD_W-1:0]  rd_data
);

    logic [WORD_W-1:0] key_mem_reg [0:(1<<ROUND_W)-1];
    logic [WORD_W-1:0] rd_data_reg;

    // Store one round key per write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem_reg[wr_addr] <= wr_data;
        end
    end

    // Register the read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= key_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sm4_round.sv
module sm4_round
    import sm4_pkg::*;
(
    input  logic [WORD_W-1:0] x0,
    input  logic [WORD_W-1:0] x1,
    input  logic [WORD_W-1:0] x2,
    input  logic [WORD_W-1:0] x3,
    input  logic [WORD_W-1:0] round_key,
    output logic [WORD_W-1:0] x_new
);

    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] sub;
    logic [WORD_W-1:0] lin;

    // Combine the three words with the key
    assign mix = x1 ^ x2 ^ x3 ^ round_key;

    // Substitute each byte
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sub[i*8 +: 8] = SBOX[mix[i*8 +: 8]];
        end
    end

    // Linear transform with rotations 2, 10, 18 and 24
    assign lin = sub
               ^ {sub[29:0], sub[31:30]}
               ^ {sub[21:0], sub[31:22]}
               ^ {sub[13:0], sub[31:14]}
               ^ {sub[7:0],  sub[31:8]};

    assign x_new = x0 ^ lin;

endmodule

>>> rtl/sm4_ctrl.sv
module sm4_ctrl
    import sm4_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_op,
    input  logic  out_free,
    output logic  in_ready,
    output ctrl_t ctrl
);

    state_t             state_reg;
    state_t             state_next;
    logic [ROUND_W-1:0] cnt_reg;
    logic [ROUND_W-1:0] cnt_next;

    // Advance state and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_op == OP_ENCRYPT))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and counter
    always_comb
    begin
        in_ready        = 1'b0;
        ctrl.key_wr     = 1'b0;
        ctrl.load_words = 1'b0;
        ctrl.round_step = 1'b0;
        ctrl.load_out   = 1'b0;
        ctrl.rd_addr    = '0;
        cnt_next        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                ctrl.key_wr     = in_valid && (in_op == OP_WRITE_KEY);
                ctrl.load_words = in_valid && (in_op == OP_ENCRYPT);
            end
            ST_ROUND:
            begin
                ctrl.round_step = 1'b1;
                ctrl.rd_addr    = cnt_reg + 1'b1;
                cnt_next        = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                ctrl.load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/sm4_block_encrypt.sv
// SM4 encryption core, one round per cycle on a shared round unit.
// Key write: the sequencer stays idle, ready again the next cycle.
// Encrypt: the key fetch overlaps the input transfer, then 32 rounds run, then
// one load of the output register raises m_axis_tvalid and reopens the input;
// that load waits for a free output, and no new block is taken before it.
// Reset clears the sequencer and output valid; the round key store is not cleared.
module sm4_block_encrypt
    import sm4_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // key_index[4:0], key_value[36:5], in_word0[68:37], in_word1[100:69],
    // in_word2[132:101], in_word3[164:133], zero pad[167:165]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // opcode[0]
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_word0[31:0], out_word1[63:32], out_word2[95:64], out_word3[127:96]
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    ctrl_t               ctrl;
    logic                in_ready;
    logic                out_free;
    logic [WORD_W-1:0]   round_key;
    logic [WORD_W-1:0]   x_new;
    logic [WORD_W-1:0]   w_reg [0:3];
    logic [WORD_W-1:0]   w_next [0:3];
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_valid_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = in_ready;

    sm4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    sm4_key_ram u_key_ram (
        .clk     (clk),
        .wr_en   (ctrl.key_wr),
        .wr_addr (s_axis_tdata[4:0]),
        .wr_data (s_axis_tdata[36:5]),
        .rd_addr (ctrl.rd_addr),
        .rd_data (round_key)
    );

    sm4_round u_round (
        .x0        (w_reg[0]),
        .x1        (w_reg[1]),
        .x2        (w_reg[2]),
        .x3        (w_reg[3]),
        .round_key (round_key),
        .x_new     (x_new)
    );

    // Load the plaintext or shift in the new word
    always_comb
    begin
        w_next = w_reg;
        if (ctrl.load_words)
        begin
            w_next[0] = s_axis_tdata[68:37];
            w_next[1] = s_axis_tdata[100:69];
            w_next[2] = s_axis_tdata[132:101];
            w_next[3] = s_axis_tdata[164:133];
        end
        else if (ctrl.round_step)
        begin
            w_next[0] = w_reg[1];
            w_next[1] = w_reg[2];
            w_next[2] = w_reg[3];
            w_next[3] = x_new;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // Hold the result in reversed word order
    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg <= {w_reg[0], w_reg[1], w_reg[2], w_reg[3]};
        end
    end

    // Track output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/sm4_block_encrypt_chk.sv
`include "sm4_block_encrypt_assert.svh"

module sm4_block_encrypt_chk
    import sm4_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // A stalled result holds
    `SM4_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // An encrypt transfer closes the input; ready is sampled once, while rounds run
    `SM4_ASSERT(a_enc_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ENCRYPT) |-> ##2 !s_axis_tready, "input reopened during rounds")

    // A key write leaves the input ready in the next cycle
    `SM4_ASSERT(a_key_one_cycle, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE_KEY) |=> s_axis_tready, "key write stalled input")

    // Reset clears any pending result
    `SM4_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind sm4_block_encrypt sm4_block_encrypt_chk u_chk (.*);
